>>> src/sdws_pkg.sv
`default_nettype none

package sdws_pkg;

   // Field widths of the request and response channels
   localparam int ACTION_W       = 3;
   localparam int VALUE_W        = 16;
   localparam int REPEAT_COUNT_W = 20;

   // Default width of the repeat counter
   localparam int COUNT_BITS_DEF = 20;

   // Shifter sizing: longest frame is a nine-bit-mode word (2 x 9 bits)
   localparam int FRAME_W = 18;
   localparam int BITS_W  = 5;

   localparam logic [BITS_W-1:0] LEN_BYTE      = BITS_W'(8);
   localparam logic [BITS_W-1:0] LEN_WORD      = BITS_W'(16);
   localparam logic [BITS_W-1:0] LEN_NINE_BYTE = BITS_W'(9);
   localparam logic [BITS_W-1:0] LEN_NINE_WORD = BITS_W'(18);

   // Register port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_NINE_BIT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CS_ENABLE = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_BEGIN     = 3'd0,
      ACT_END       = 3'd1,
      ACT_CMD_BYTE  = 3'd2,
      ACT_CMD_WORD  = 3'd3,
      ACT_DATA_BYTE = 3'd4,
      ACT_DATA_WORD = 3'd5,
      ACT_REPEAT    = 3'd6,
      ACT_TICK      = 3'd7
   } action_type;

   typedef struct packed {
      logic nine_bit_mode;
      logic cs_enabled;
   } cfg_type;

   typedef struct packed {
      logic mosi;
      logic dc;
      logic cs_n;
      logic last_bit;
   } result_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [BITS_W-1:0]  len;
   } frame_type;

   // Serial frame for one byte or word, MSB at bit len-1
   function automatic frame_type build_frame(input logic [VALUE_W-1:0] v,
                                             input logic               is_word,
                                             input logic               dcbit,
                                             input logic               nine);
      frame_type f;
      f = '0;
      if (nine) begin
         if (is_word) begin
            f.frame = {dcbit, v[15:8], dcbit, v[7:0]};
            f.len   = LEN_NINE_WORD;
         end else begin
            f.frame = {9'd0, dcbit, v[7:0]};
            f.len   = LEN_NINE_BYTE;
         end
      end else begin
         if (is_word) begin
            f.frame = {2'd0, v};
            f.len   = LEN_WORD;
         end else begin
            f.frame = {10'd0, v[7:0]};
            f.len   = LEN_BYTE;
         end
      end
      return f;
   endfunction

endpackage

`default_nettype wire

>>> src/sdws_if.sv
`default_nettype none

// Request channel: one load or tick per request
interface sdws_req_if;
   import sdws_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic [VALUE_W-1:0]        value;
   logic [REPEAT_COUNT_W-1:0] repeat_count;

   modport source (output valid, action, value, repeat_count, input ready);
   modport sink   (input valid, action, value, repeat_count, output ready);
endinterface

// Response channel: line levels for one serial bit
interface sdws_rsp_if;
   logic valid;
   logic ready;
   logic mosi;
   logic dc;
   logic cs_n;
   logic last_bit;

   modport source (output valid, mosi, dc, cs_n, last_bit, input ready);
   modport sink   (input valid, mosi, dc, cs_n, last_bit, output ready);
endinterface

// Register write channel
interface sdws_csr_if;
   import sdws_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/sdws_engine.sv
`default_nettype none

module sdws_engine
   import sdws_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            accept,
   input  wire action_type                action,
   input  wire logic [VALUE_W-1:0]        value,
   input  wire logic [REPEAT_COUNT_W-1:0] repeat_count,
   input  wire cfg_type                   cfg,
   output logic                           push,
   output result_type                     result
);

   // Counter keeps only the count bits that can reach it
   localparam int CNT_W = (COUNT_BITS < REPEAT_COUNT_W) ? COUNT_BITS : REPEAT_COUNT_W;

   logic [FRAME_W-1:0] shift_word_ff, shift_word_in;
   logic [BITS_W-1:0]  bits_left_ff, bits_left_in;
   logic [CNT_W-1:0]   repeats_left_ff, repeats_left_in;
   logic [VALUE_W-1:0] repeat_word_ff, repeat_word_in;
   logic               dc_level_ff, dc_level_in;
   logic               cs_active_ff, cs_active_in;

   logic               busy;
   logic               is_word;
   logic               is_data;
   frame_type          frame_req;
   frame_type          frame_rep;
   logic [FRAME_W-1:0] shift_cur;
   logic [BITS_W-1:0]  bits_cur;
   logic [CNT_W-1:0]   reps_cur;
   logic               last;

   assign busy    = (bits_left_ff != '0) || (repeats_left_ff != '0);
   assign is_word = (action == ACT_CMD_WORD) || (action == ACT_DATA_WORD);
   assign is_data = (action == ACT_DATA_BYTE) || (action == ACT_DATA_WORD);

   assign frame_req = build_frame(value, is_word, is_data, cfg.nine_bit_mode);
   assign frame_rep = build_frame(repeat_word_ff, 1'b1, 1'b1, cfg.nine_bit_mode);

   // Tick path: reload from the repeat word when the shifter ran dry
   always_comb begin
      if (bits_left_ff == '0) begin
         shift_cur = frame_rep.frame;
         bits_cur  = frame_rep.len - 1'b1;
         reps_cur  = repeats_left_ff - 1'b1;
      end else begin
         shift_cur = shift_word_ff;
         bits_cur  = bits_left_ff - 1'b1;
         reps_cur  = repeats_left_ff;
      end
      last = (bits_cur == '0) && (reps_cur == '0);
   end

   // Next state and result for one request
   always_comb begin
      shift_word_in   = shift_word_ff;
      bits_left_in    = bits_left_ff;
      repeats_left_in = repeats_left_ff;
      repeat_word_in  = repeat_word_ff;
      dc_level_in     = dc_level_ff;
      cs_active_in    = cs_active_ff;
      push            = 1'b0;
      result.mosi     = shift_cur[0];
      result.dc       = dc_level_ff;
      result.cs_n     = cfg.cs_enabled ? ~cs_active_ff : 1'b1;
      result.last_bit = last;

      if (accept) begin
         if (action == ACT_TICK) begin
            if (busy) begin
               push            = 1'b1;
               result.mosi     = shift_cur[bits_cur];
               shift_word_in   = shift_cur;
               bits_left_in    = bits_cur;
               repeats_left_in = reps_cur;
               if (last) begin
                  dc_level_in = 1'b1;
               end
            end
         end else if (!busy) begin
            case (action)
               ACT_BEGIN: begin
                  dc_level_in  = 1'b1;
                  cs_active_in = 1'b1;
               end
               ACT_END: begin
                  cs_active_in = 1'b0;
               end
               ACT_CMD_BYTE, ACT_CMD_WORD: begin
                  dc_level_in   = 1'b0;
                  shift_word_in = frame_req.frame;
                  bits_left_in  = frame_req.len;
               end
               ACT_DATA_BYTE, ACT_DATA_WORD: begin
                  dc_level_in   = 1'b1;
                  shift_word_in = frame_req.frame;
                  bits_left_in  = frame_req.len;
               end
               ACT_REPEAT: begin
                  dc_level_in     = 1'b1;
                  repeat_word_in  = value;
                  repeats_left_in = repeat_count[CNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_word_ff   <= '0;
         bits_left_ff    <= '0;
         repeats_left_ff <= '0;
         repeat_word_ff  <= '0;
         dc_level_ff     <= 1'b1;
         cs_active_ff    <= 1'b0;
      end else begin
         shift_word_ff   <= shift_word_in;
         bits_left_ff    <= bits_left_in;
         repeats_left_ff <= repeats_left_in;
         repeat_word_ff  <= repeat_word_in;
         dc_level_ff     <= dc_level_in;
         cs_active_ff    <= cs_active_in;
      end
   end

`ifndef SYNTHESIS
   // Shifter never holds more than one nine-bit word
   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= LEN_NINE_WORD)
      else $error("bits_left exceeds frame length");

   // A response only comes from a pending write
   a_push_busy: assert property (@(posedge clock) disable iff (reset)
      push |-> busy)
      else $error("response without pending write");

   // Final bit of a write returns DC to data and leaves the shifter idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (push && result.last_bit) |=> (dc_level_ff && !busy))
      else $error("write did not finish cleanly");
`endif

endmodule

`default_nettype wire

>>> src/spi_display_write_serializer_top.sv
`default_nettype none

// Write-only serial display link master, MSB first. Each request is a load
// (begin/end transaction, command or data byte/word, repeated data word) or
// a tick; every tick while a write is pending yields one response with the
// MOSI, DC and CS_N levels for that serial clock pulse plus a last-bit flag.
// Loads arriving while a write is pending are dropped, ticks while idle give
// no response. The block takes one request per clock: all state updates in
// the cycle of acceptance, the response is registered into the output
// register, and a second output entry absorbs one stalled response so
// that requests keep flowing; req.ready drops only while both entries hold
// responses. Registers (nine-bit mode, chip-select enable) are written
// through the csr port, which is always ready.
module spi_display_write_serializer_top
   import sdws_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input wire       clock,
   input wire       reset,
   sdws_req_if.sink   req,
   sdws_rsp_if.source rsp,
   sdws_csr_if.sink   csr
);

   cfg_type    cfg_ff;
   logic       accept;
   logic       push;
   logic       pop;
   result_type result;

   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   result_type skid_ff, skid_in;
   logic       skid_valid_ff, skid_valid_in;

   // Register port
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nine_bit_mode <= 1'b0;
         cfg_ff.cs_enabled    <= 1'b1;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_NINE_BIT:  cfg_ff.nine_bit_mode <= csr.data[0];
            CSR_CS_ENABLE: cfg_ff.cs_enabled    <= csr.data[0];
            default: begin
            end
         endcase
      end
   end

   assign req.ready = ~skid_valid_ff;
   assign accept    = req.valid && req.ready;

   sdws_engine #(
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (action_type'(req.action)),
      .value        (req.value),
      .repeat_count (req.repeat_count),
      .cfg          (cfg_ff),
      .push         (push),
      .result       (result)
   );

   // Two-entry output stage: output register plus skid entry
   assign pop = out_valid_ff && rsp.ready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && !pop) begin
         if (push) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else begin
         out_in       = result;
         out_valid_in = push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.mosi     = out_ff.mosi;
   assign rsp.dc       = out_ff.dc;
   assign rsp.cs_n     = out_ff.cs_n;
   assign rsp.last_bit = out_ff.last_bit;

`ifndef SYNTHESIS
   // Skid entry is only ever filled behind a full output register
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // Draining the skid entry keeps the output register occupied
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp.ready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry lost on drain");

   // A response pushed while the output register is full must fit in the skid entry
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("response pushed into full output stage");
`endif

endmodule

`default_nettype wire
